// ----- design/ept_pkg.sv -----
`default_nettype none

package ept_pkg;

   // default fractional bits of the sine and cosine values
   localparam int TRIG_FRAC_BITS_DEF = 20;
   localparam int TRIG_FRAC_MIN = 16;
   localparam int TRIG_FRAC_MAX = 30;

   // internal angle work format is 0.30
   localparam int WORK_BITS = 30;

   // angle reduction, hundredths of a degree
   localparam int FULL_TURN    = 36000;
   localparam int HALF_TURN    = 18000;
   localparam int QUARTER_TURN = 9000;
   localparam int EIGHTH_TURN  = 4500;
   localparam int TWO_TURNS    = 72000;
   localparam int THREE_TURNS  = 108000;

   // pi in 2.30 split as HI * 18000 + LO, so w * pi / 18000 = w * HI + w * LO / 18000
   localparam logic [31:0] PI_HI = 32'd187403;
   localparam logic [31:0] PI_LO = 32'd5426;
   localparam int RCP_HALF_SHR = 45;
   localparam logic [63:0] RCP_HALF_TURN =
      ((64'd1 << RCP_HALF_SHR) + 64'(HALF_TURN) - 64'd1) / 64'(HALF_TURN);

   // millimetres to centimetres
   localparam int MM_PER_CM = 10;
   localparam int RCP_CM_SHR = 28;
   localparam logic [63:0] RCP_CM =
      ((64'd1 << RCP_CM_SHR) + 64'(MM_PER_CM) - 64'd1) / 64'(MM_PER_CM);

   localparam int HUNDRED = 100;

   // reciprocals of the factorials 2! .. 10! for the series terms
   localparam int FACT_SHR [2:10] = '{31, 33, 35, 37, 40, 43, 46, 49, 52};
   localparam logic [63:0] FACT_RCP [2:10] = '{
      ((64'd1 << 31) + 64'd2 - 64'd1) / 64'd2,
      ((64'd1 << 33) + 64'd6 - 64'd1) / 64'd6,
      ((64'd1 << 35) + 64'd24 - 64'd1) / 64'd24,
      ((64'd1 << 37) + 64'd120 - 64'd1) / 64'd120,
      ((64'd1 << 40) + 64'd720 - 64'd1) / 64'd720,
      ((64'd1 << 43) + 64'd5040 - 64'd1) / 64'd5040,
      ((64'd1 << 46) + 64'd40320 - 64'd1) / 64'd40320,
      ((64'd1 << 49) + 64'd362880 - 64'd1) / 64'd362880,
      ((64'd1 << 52) + 64'd3628800 - 64'd1) / 64'd3628800};

   localparam logic [1:0] ROW_LAST = 2'd3;

   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quad_type;

   // per-angle control carried down to the sign fix-up
   typedef struct packed {
      quad_type quad;
      logic     swap;
   } lane_ctl_type;

   // translation and passed-through row carried alongside the trig work
   typedef struct packed {
      logic [2:0][23:0] tr;
      logic [3:0][23:0] r3;
   } carry_type;

   // 0.30 product truncated back to 0.30
   function automatic logic [29:0] wmul(input logic [29:0] a, input logic [29:0] b);
      logic [59:0] p;
      p = 60'(a) * 60'(b);
      return p[59:30];
   endfunction

   // power divided by k!, by reciprocal multiply, exact for 30 bit values
   function automatic logic [29:0] fact_div(input logic [29:0] x, input int k);
      logic [63:0] p;
      p = 64'(x) * FACT_RCP[k];
      return 30'(p >> FACT_SHR[k]);
   endfunction

endpackage

`default_nettype wire

// ----- design/euler_pose_to_transform_matrix.sv -----
`default_nettype none

// Euler ZYX pose to 4x4 homogeneous transform. Each request beat carries three
// angles in hundredths of a degree, a translation in mm and the bottom row of a
// previous matrix; the block answers with four response beats, the rows of the
// transposed matrix, entries in hundredths (translation in cm), last_row set on
// the fourth. Sine and cosine come from a Taylor series in a 14 stage pipeline,
// followed by the output register that offers the rows. The response port
// sends one row per cycle while rsp_stall is low; a new request is taken only
// while the output register is empty or its last row is sent, so the whole
// pipeline holds while the output register still has rows to send.

module euler_pose_to_transform_matrix #(
   parameter int TRIG_FRAC_BITS = ept_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [16:0] req_angle_a,
   input  wire logic signed [16:0] req_angle_b,
   input  wire logic signed [16:0] req_angle_c,
   input  wire logic signed [23:0] req_shift_x_mm,
   input  wire logic signed [23:0] req_shift_y_mm,
   input  wire logic signed [23:0] req_shift_z_mm,
   input  wire logic signed [23:0] req_old_row3_e0,
   input  wire logic signed [23:0] req_old_row3_e1,
   input  wire logic signed [23:0] req_old_row3_e2,
   input  wire logic signed [23:0] req_old_row3_e3,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_row_number,
   output logic signed [23:0]      rsp_entry_0,
   output logic signed [23:0]      rsp_entry_1,
   output logic signed [23:0]      rsp_entry_2,
   output logic signed [23:0]      rsp_entry_3,
   output logic                    rsp_last_row
);

   localparam int F = (TRIG_FRAC_BITS < ept_pkg::TRIG_FRAC_MIN) ? ept_pkg::TRIG_FRAC_MIN :
                      (TRIG_FRAC_BITS > ept_pkg::TRIG_FRAC_MAX) ? ept_pkg::TRIG_FRAC_MAX :
                      TRIG_FRAC_BITS;
   localparam int TW = F + 2;
   localparam int SW = F + 3;
   localparam int PW = 2 * TW;
   localparam int HW = SW + 7;
   localparam int SH = ept_pkg::WORK_BITS - F;
   localparam logic [31:0] FRAC_HALF = (32'd1 << SH) >> 1;
   localparam int NST = 14;

   // 2.F product rounded half away from zero
   function automatic logic signed [TW-1:0] fmul(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
      logic signed [PW-1:0] p;
      logic [PW-1:0] m;
      p = PW'(a) * PW'(b);
      m = p[PW-1] ? PW'(-p) : PW'(p);
      m = (m + (PW'(1) << (F - 1))) >> F;
      return p[PW-1] ? TW'(-m) : TW'(m);
   endfunction

   // 3.F value to hundredths, half away from zero
   function automatic logic [23:0] hund(input logic signed [SW-1:0] v);
      logic signed [HW-1:0] p;
      logic [HW-1:0] m;
      p = HW'(v) * HW'(ept_pkg::HUNDRED);
      m = p[HW-1] ? HW'(-p) : HW'(p);
      m = (m + (HW'(1) << (F - 1))) >> F;
      return p[HW-1] ? 24'(-m) : 24'(m);
   endfunction

   // mm to cm, half away from zero
   function automatic logic [23:0] mm_to_cm(input logic [23:0] mm);
      logic [23:0] mag;
      logic [63:0] p;
      mag = mm[23] ? 24'(-mm) : mm;
      p = 64'(mag + 24'(ept_pkg::MM_PER_CM / 2)) * ept_pkg::RCP_CM;
      p = p >> ept_pkg::RCP_CM_SHR;
      return mm[23] ? 24'(-p) : 24'(p);
   endfunction

   // pipeline advance: output register free or sending its last row
   logic adv;
   logic vld_ff [1:NST];
   ept_pkg::carry_type carry_ff [1:NST];
   ept_pkg::carry_type carry_in;
   logic hold_vld_ff;
   logic [1:0] row_ff;

   assign adv = !hold_vld_ff || (row_ff == ept_pkg::ROW_LAST && !rsp_stall);
   assign req_stall = !adv;

   logic signed [16:0] ang [3];
   assign ang[0] = req_angle_a;
   assign ang[1] = req_angle_b;
   assign ang[2] = req_angle_c;

   // stage 1: translation to cm, angle reduced into one turn
   logic [15:0] red_in [3];
   logic [15:0] red_ff [3];
   logic [17:0] turn_v [3];

   always_comb begin
      carry_in.tr[0] = mm_to_cm(req_shift_x_mm);
      carry_in.tr[1] = mm_to_cm(req_shift_y_mm);
      carry_in.tr[2] = mm_to_cm(req_shift_z_mm);
      carry_in.r3[0] = req_old_row3_e0;
      carry_in.r3[1] = req_old_row3_e1;
      carry_in.r3[2] = req_old_row3_e2;
      carry_in.r3[3] = req_old_row3_e3;
      for (int i = 0; i < 3; i++) begin
         turn_v[i] = 18'({ang[i][16], ang[i]}) + 18'(ept_pkg::TWO_TURNS);
         if (turn_v[i] >= 18'(ept_pkg::THREE_TURNS)) begin
            red_in[i] = 16'(turn_v[i] - 18'(ept_pkg::THREE_TURNS));
         end else if (turn_v[i] >= 18'(ept_pkg::TWO_TURNS)) begin
            red_in[i] = 16'(turn_v[i] - 18'(ept_pkg::TWO_TURNS));
         end else if (turn_v[i] >= 18'(ept_pkg::FULL_TURN)) begin
            red_in[i] = 16'(turn_v[i] - 18'(ept_pkg::FULL_TURN));
         end else begin
            red_in[i] = 16'(turn_v[i]);
         end
      end
   end

   // stage 2: quadrant and fold about 45 degrees
   ept_pkg::lane_ctl_type ctl_in [3];
   ept_pkg::lane_ctl_type ctl_ff [2:9][3];
   logic [13:0] qw [3];
   logic [12:0] fold_in [3];
   logic [12:0] fold_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (red_ff[i] >= 16'(3 * ept_pkg::QUARTER_TURN)) begin
            ctl_in[i].quad = ept_pkg::QUAD_FOURTH;
            qw[i] = 14'(red_ff[i] - 16'(3 * ept_pkg::QUARTER_TURN));
         end else if (red_ff[i] >= 16'(ept_pkg::HALF_TURN)) begin
            ctl_in[i].quad = ept_pkg::QUAD_THIRD;
            qw[i] = 14'(red_ff[i] - 16'(ept_pkg::HALF_TURN));
         end else if (red_ff[i] >= 16'(ept_pkg::QUARTER_TURN)) begin
            ctl_in[i].quad = ept_pkg::QUAD_SECOND;
            qw[i] = 14'(red_ff[i] - 16'(ept_pkg::QUARTER_TURN));
         end else begin
            ctl_in[i].quad = ept_pkg::QUAD_FIRST;
            qw[i] = 14'(red_ff[i]);
         end
         ctl_in[i].swap = qw[i] > 14'(ept_pkg::EIGHTH_TURN);
         fold_in[i] = ctl_in[i].swap ? 13'(14'(ept_pkg::QUARTER_TURN) - qw[i]) : 13'(qw[i]);
      end
   end

   // stage 3: angle times pi, split into whole and remainder parts
   logic [24:0] xr_ff [3];
   logic [30:0] wa_ff [3];
   // stage 4: angle in radians, 0.30
   logic [29:0] t_in [3];
   logic [63:0] tq [3];
   // stages 5 to 8: powers of t, index 1 is t itself
   logic [29:0] pw5_ff [3][1:2];
   logic [29:0] pw6_ff [3][1:4];
   logic [29:0] pw7_ff [3][1:6];
   logic [29:0] pw7_p8_ff [3];
   logic [29:0] pw8_ff [3][1:10];
   // stage 9: series terms
   logic [29:0] tm_ff [3][1:10];
   // stage 10: signed sine and cosine, 2.F
   logic signed [TW-1:0] sin_in [3];
   logic signed [TW-1:0] cos_in [3];
   logic signed [TW-1:0] sin_ff [3];
   logic signed [TW-1:0] cos_ff [3];
   logic [31:0] s_sum [3];
   logic [31:0] c_sum [3];
   logic [31:0] s_fr [3];
   logic [31:0] c_fr [3];
   logic signed [TW-1:0] s0 [3];
   logic signed [TW-1:0] c0 [3];
   logic [29:0] t4_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tq[i] = 64'(xr_ff[i]) * ept_pkg::RCP_HALF_TURN;
         t_in[i] = 30'(32'(wa_ff[i]) + 32'(tq[i] >> ept_pkg::RCP_HALF_SHR));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_sum[i] = 32'(tm_ff[i][1]) + 32'(tm_ff[i][5]) + 32'(tm_ff[i][9])
                    - 32'(tm_ff[i][3]) - 32'(tm_ff[i][7]);
         c_sum[i] = (32'd1 << ept_pkg::WORK_BITS) + 32'(tm_ff[i][4]) + 32'(tm_ff[i][8])
                    - 32'(tm_ff[i][2]) - 32'(tm_ff[i][6]) - 32'(tm_ff[i][10]);
         s_fr[i] = (s_sum[i] + FRAC_HALF) >> SH;
         c_fr[i] = (c_sum[i] + FRAC_HALF) >> SH;
         s0[i] = ctl_ff[9][i].swap ? TW'(c_fr[i]) : TW'(s_fr[i]);
         c0[i] = ctl_ff[9][i].swap ? TW'(s_fr[i]) : TW'(c_fr[i]);
         case (ctl_ff[9][i].quad)
            ept_pkg::QUAD_FIRST: begin
               sin_in[i] = s0[i];
               cos_in[i] = c0[i];
            end
            ept_pkg::QUAD_SECOND: begin
               sin_in[i] = c0[i];
               cos_in[i] = -s0[i];
            end
            ept_pkg::QUAD_THIRD: begin
               sin_in[i] = -s0[i];
               cos_in[i] = -c0[i];
            end
            default: begin
               sin_in[i] = -c0[i];
               cos_in[i] = s0[i];
            end
         endcase
      end
   end

   // stage 11: first products; stage 12: triple products; stage 13: sums
   logic signed [TW-1:0] casb_ff, sasb_ff, cacb_ff, sacg_ff, sasg_ff, sacb_ff;
   logic signed [TW-1:0] cacg_ff, casg_ff, cbsg_ff, cbcg_ff, sb_ff, sg1_ff, cg1_ff;
   logic signed [TW-1:0] k1_ff, k2_ff, k3_ff, k4_ff;
   logic signed [TW-1:0] sacg2_ff, sasg2_ff, cacg2_ff, casg2_ff;
   logic signed [TW-1:0] cacb2_ff, sacb2_ff, cbsg2_ff, cbcg2_ff, sb2_ff;
   logic signed [SW-1:0] sum_ff [9];
   logic [23:0] hm_ff [9];
   logic [23:0] out_m_ff [9];
   ept_pkg::carry_type out_carry_ff;

   // valid bits and the output row counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 1; n <= NST; n++) begin
            vld_ff[n] <= 1'b0;
         end
         hold_vld_ff <= 1'b0;
         row_ff <= 2'd0;
      end else if (adv) begin
         vld_ff[1] <= req_valid;
         for (int n = 2; n <= NST; n++) begin
            vld_ff[n] <= vld_ff[n-1];
         end
         hold_vld_ff <= vld_ff[NST];
         row_ff <= 2'd0;
      end else if (!rsp_stall) begin
         row_ff <= row_ff + 2'd1;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         carry_ff[1] <= carry_in;
         for (int n = 2; n <= NST; n++) begin
            carry_ff[n] <= carry_ff[n-1];
         end
         for (int i = 0; i < 3; i++) begin
            red_ff[i] <= red_in[i];
            fold_ff[i] <= fold_in[i];
            ctl_ff[2][i] <= ctl_in[i];
            for (int n = 3; n <= 9; n++) begin
               ctl_ff[n][i] <= ctl_ff[n-1][i];
            end
            xr_ff[i] <= 25'(32'(fold_ff[i]) * ept_pkg::PI_LO + 32'(ept_pkg::QUARTER_TURN));
            wa_ff[i] <= 31'(32'(fold_ff[i]) * ept_pkg::PI_HI);
            t4_ff[i] <= t_in[i];
            // powers, one multiply level per stage
            pw5_ff[i][1] <= t4_ff[i];
            pw5_ff[i][2] <= ept_pkg::wmul(t4_ff[i], t4_ff[i]);
            pw6_ff[i][1] <= pw5_ff[i][1];
            pw6_ff[i][2] <= pw5_ff[i][2];
            pw6_ff[i][3] <= ept_pkg::wmul(pw5_ff[i][2], pw5_ff[i][1]);
            pw6_ff[i][4] <= ept_pkg::wmul(pw5_ff[i][2], pw5_ff[i][2]);
            for (int k = 1; k <= 4; k++) begin
               pw7_ff[i][k] <= pw6_ff[i][k];
            end
            pw7_ff[i][5] <= ept_pkg::wmul(pw6_ff[i][4], pw6_ff[i][1]);
            pw7_ff[i][6] <= ept_pkg::wmul(pw6_ff[i][4], pw6_ff[i][2]);
            pw7_p8_ff[i] <= ept_pkg::wmul(pw6_ff[i][4], pw6_ff[i][4]);
            for (int k = 1; k <= 6; k++) begin
               pw8_ff[i][k] <= pw7_ff[i][k];
            end
            pw8_ff[i][7] <= ept_pkg::wmul(pw7_ff[i][6], pw7_ff[i][1]);
            pw8_ff[i][8] <= pw7_p8_ff[i];
            pw8_ff[i][9] <= ept_pkg::wmul(pw7_p8_ff[i], pw7_ff[i][1]);
            pw8_ff[i][10] <= ept_pkg::wmul(pw7_p8_ff[i], pw7_ff[i][2]);
            // series terms
            tm_ff[i][1] <= pw8_ff[i][1];
            for (int k = 2; k <= 10; k++) begin
               tm_ff[i][k] <= ept_pkg::fact_div(pw8_ff[i][k], k);
            end
            sin_ff[i] <= sin_in[i];
            cos_ff[i] <= cos_in[i];
         end
         // rotation products
         casb_ff <= fmul(cos_ff[0], sin_ff[1]);
         sasb_ff <= fmul(sin_ff[0], sin_ff[1]);
         cacb_ff <= fmul(cos_ff[0], cos_ff[1]);
         sacg_ff <= fmul(sin_ff[0], cos_ff[2]);
         sasg_ff <= fmul(sin_ff[0], sin_ff[2]);
         sacb_ff <= fmul(sin_ff[0], cos_ff[1]);
         cacg_ff <= fmul(cos_ff[0], cos_ff[2]);
         casg_ff <= fmul(cos_ff[0], sin_ff[2]);
         cbsg_ff <= fmul(cos_ff[1], sin_ff[2]);
         cbcg_ff <= fmul(cos_ff[1], cos_ff[2]);
         sb_ff <= sin_ff[1];
         sg1_ff <= sin_ff[2];
         cg1_ff <= cos_ff[2];
         k1_ff <= fmul(casb_ff, sg1_ff);
         k2_ff <= fmul(casb_ff, cg1_ff);
         k3_ff <= fmul(sasb_ff, sg1_ff);
         k4_ff <= fmul(sasb_ff, cg1_ff);
         sacg2_ff <= sacg_ff;
         sasg2_ff <= sasg_ff;
         cacg2_ff <= cacg_ff;
         casg2_ff <= casg_ff;
         cacb2_ff <= cacb_ff;
         sacb2_ff <= sacb_ff;
         cbsg2_ff <= cbsg_ff;
         cbcg2_ff <= cbcg_ff;
         sb2_ff <= sb_ff;
         // matrix entries, row major
         sum_ff[0] <= SW'(cacb2_ff);
         sum_ff[1] <= SW'(k1_ff) - SW'(sacg2_ff);
         sum_ff[2] <= SW'(k2_ff) + SW'(sasg2_ff);
         sum_ff[3] <= SW'(sacb2_ff);
         sum_ff[4] <= SW'(k3_ff) + SW'(cacg2_ff);
         sum_ff[5] <= SW'(k4_ff) - SW'(casg2_ff);
         sum_ff[6] <= -SW'(sb2_ff);
         sum_ff[7] <= SW'(cbsg2_ff);
         sum_ff[8] <= SW'(cbcg2_ff);
         for (int j = 0; j < 9; j++) begin
            hm_ff[j] <= hund(sum_ff[j]);
            out_m_ff[j] <= hm_ff[j];
         end
         out_carry_ff <= carry_ff[NST];
      end
   end

   // response beat: row k of the transpose is column k of the matrix
   always_comb begin
      case (row_ff)
         2'd0: begin
            rsp_entry_0 = out_m_ff[0];
            rsp_entry_1 = out_m_ff[3];
            rsp_entry_2 = out_m_ff[6];
         end
         2'd1: begin
            rsp_entry_0 = out_m_ff[1];
            rsp_entry_1 = out_m_ff[4];
            rsp_entry_2 = out_m_ff[7];
         end
         2'd2: begin
            rsp_entry_0 = out_m_ff[2];
            rsp_entry_1 = out_m_ff[5];
            rsp_entry_2 = out_m_ff[8];
         end
         default: begin
            rsp_entry_0 = out_carry_ff.tr[0];
            rsp_entry_1 = out_carry_ff.tr[1];
            rsp_entry_2 = out_carry_ff.tr[2];
         end
      endcase
      rsp_entry_3 = out_carry_ff.r3[row_ff];
   end

   assign rsp_valid = hold_vld_ff;
   assign rsp_row_number = row_ff;
   assign rsp_last_row = (row_ff == ept_pkg::ROW_LAST);

endmodule

`default_nettype wire
